[sv/partial_order_chain_extract_macros.svh]
// ----------------------------------------------------------------------------
// partial_order_chain_extract assertion macros
// Shared property shapes, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PARTIAL_ORDER_CHAIN_EXTRACT_MACROS_SVH
`define PARTIAL_ORDER_CHAIN_EXTRACT_MACROS_SVH

// same-cycle implication
`define POCE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POCE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/poce_pkg.sv]
// ----------------------------------------------------------------------------
// poce_pkg
// Types, sizes and codes shared by the chain extraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package poce_pkg;

  localparam int MAX_TASKS    = 16;
  localparam int TASK_ID_BITS = 16;
  localparam int IDX_W        = $clog2(MAX_TASKS);
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    OP_LOAD_ID   = 2'd0,
    OP_LOAD_EDGE = 2'd1,
    OP_GO        = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [3:0]              slot;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [3:0]              edge_from;
    logic [3:0]              edge_to;
    logic [4:0]              task_count;
  } in_item_t;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] out_task_id;
    logic [3:0]              position;
    logic                    last;
    logic                    error;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CLOSE,
    S_MARK,
    S_PRUNE,
    S_FIND,
    S_WALK,
    S_EMIT,
    S_ERR,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic idx_clr;
    logic idx_inc;
    logic close_step;
    logic mark_step;
    logic prune;
    logic find_end;
    logic walk_step;
    logic emit_step;
    logic emit_err;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_go;
    logic out_free;
    logic check_err;
    logic idx_last;
    logic end_found;
    logic pred_found;
    logic walk_over;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

[sv/poce_if.sv]
// ----------------------------------------------------------------------------
// poce_if
// Valid/ready channels for load/go items and for chain results.
// ----------------------------------------------------------------------------
`default_nettype none

interface poce_in_if import poce_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface poce_out_if import poce_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/poce_ctrl.sv]
// ----------------------------------------------------------------------------
// poce_ctrl
// Run sequencer: check, closure, marking, pruning, end search, walk, emit or error, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module poce_ctrl import poce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (st.in_valid && st.in_go) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = st.check_err ? S_ERR : S_CLOSE;
      end
      S_CLOSE: begin
        if (st.idx_last) state_next = S_MARK;
      end
      S_MARK: begin
        if (st.idx_last) state_next = S_PRUNE;
      end
      S_PRUNE: state_next = S_FIND;
      S_FIND: begin
        state_next = st.end_found ? S_WALK : S_ERR;
      end
      S_WALK: begin
        if (!st.pred_found) state_next = S_EMIT;
        else if (st.walk_over) state_next = S_ERR;
      end
      S_EMIT: begin
        if (st.out_free && st.emit_last) state_next = S_CLEAR;
      end
      S_ERR: begin
        if (st.out_free) state_next = S_CLEAR;
      end
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.accept_en = 1'b1;
      S_CHECK: cmd.idx_clr = 1'b1;
      S_CLOSE: begin
        cmd.close_step = 1'b1;
        cmd.idx_inc    = !st.idx_last;
        cmd.idx_clr    = st.idx_last;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        cmd.idx_inc   = 1'b1;
      end
      S_PRUNE: cmd.prune = 1'b1;
      S_FIND:  cmd.find_end = st.end_found;
      S_WALK: begin
        cmd.walk_step = st.pred_found && !st.walk_over;
        cmd.idx_clr   = !st.pred_found;
      end
      S_EMIT: begin
        cmd.emit_step = st.out_free;
        cmd.idx_inc   = st.out_free;
      end
      S_ERR:   cmd.emit_err = st.out_free;
      S_CLEAR: cmd.clear = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/poce_dp.sv]
// ----------------------------------------------------------------------------
// poce_dp
// Edge matrix, implied marks, slot ids, chain buffer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "partial_order_chain_extract_macros.svh"

module poce_dp import poce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  poce_in_if.sink    in_ch,
  poce_out_if.source out_ch,
  input  cmd_t       cmd,
  output status_t    st
);

  logic [MAX_TASKS-1:0]    adj [MAX_TASKS];
  logic [MAX_TASKS-1:0]    implied [MAX_TASKS];
  logic                    bad_flag;
  logic [TASK_ID_BITS-1:0] slot_ids [MAX_TASKS];
  logic [IDX_W-1:0]        chain [MAX_TASKS];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        len;
  logic [CNT_W-1:0]        idx;
  logic [IDX_W-1:0]        cur;
  logic                    out_valid;
  out_item_t               out_data;

  logic                    in_fire;
  logic [MAX_TASKS-1:0]    live;
  logic                    check_err;
  logic [IDX_W-1:0]        k;
  logic [MAX_TASKS-1:0]    mark_row;
  logic                    end_found;
  logic [IDX_W-1:0]        end_idx;
  logic                    pred_found;
  logic [IDX_W-1:0]        pred_idx;
  logic                    any_edge;
  logic [CNT_W-1:0]        rd_pos;

  assign in_ch.ready  = cmd.accept_en;
  assign in_fire      = in_ch.valid && cmd.accept_en;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign k            = idx[IDX_W-1:0];

  always_comb begin
    live      = '0;
    check_err = bad_flag || (count == '0) || (count > CNT_W'(MAX_TASKS));
    mark_row  = '0;
    end_found = 1'b0;
    end_idx   = '0;
    pred_found = 1'b0;
    pred_idx  = '0;
    any_edge  = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      live[i] = CNT_W'(i) < count;
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      if ((adj[i] & ~live) != '0) check_err = 1'b1;
      if (!live[i] && adj[i] != '0) check_err = 1'b1;
      if (adj[k][i]) mark_row = mark_row | adj[i];
      if (adj[i] != '0) any_edge = 1'b1;
    end
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (live[i] && adj[i] == '0) begin
        end_found = 1'b1;
        end_idx   = IDX_W'(i);
      end
      if (live[i] && adj[i][cur]) begin
        pred_found = 1'b1;
        pred_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_pos = len - CNT_W'(1) - idx;

  always_comb begin
    st.in_valid   = in_ch.valid;
    st.in_go      = in_ch.data.opcode == OP_GO;
    st.out_free   = !out_valid || out_ch.ready;
    st.check_err  = check_err;
    st.idx_last   = ({1'b0, idx} + (CNT_W + 1)'(1)) == {1'b0, count};
    st.end_found  = end_found;
    st.pred_found = pred_found;
    st.walk_over  = len >= count;
    st.emit_last  = ({1'b0, idx} + (CNT_W + 1)'(1)) == {1'b0, len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        adj[i]     <= '0;
        implied[i] <= '0;
      end
      bad_flag <= 1'b0;
    end else if (cmd.clear) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        adj[i]     <= '0;
        implied[i] <= '0;
      end
      bad_flag <= 1'b0;
    end else begin
      if (in_fire && in_ch.data.opcode == OP_LOAD_EDGE) begin
        if (CNT_W'(in_ch.data.edge_from) < CNT_W'(MAX_TASKS) &&
            CNT_W'(in_ch.data.edge_to) < CNT_W'(MAX_TASKS)) begin
          adj[in_ch.data.edge_from][in_ch.data.edge_to] <= 1'b1;
        end else begin
          bad_flag <= 1'b1;
        end
      end
      if (cmd.close_step) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (adj[i][k]) adj[i] <= adj[i] | adj[k];
        end
      end
      if (cmd.mark_step) implied[k] <= mark_row;
      if (cmd.prune) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          adj[i] <= adj[i] & ~implied[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      len <= '0;
    end else begin
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + CNT_W'(1);
      if (cmd.find_end) len <= CNT_W'(1);
      else if (cmd.walk_step) len <= len + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.data.opcode == OP_LOAD_ID &&
        CNT_W'(in_ch.data.slot) < CNT_W'(MAX_TASKS)) begin
      slot_ids[in_ch.data.slot] <= in_ch.data.task_id;
    end
    if (in_fire && in_ch.data.opcode == OP_GO) count <= in_ch.data.task_count;
    if (cmd.find_end) begin
      cur      <= end_idx;
      chain[0] <= end_idx;
    end
    if (cmd.walk_step) begin
      cur                     <= pred_idx;
      chain[len[IDX_W-1:0]]   <= pred_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_data.out_task_id <= slot_ids[chain[rd_pos[IDX_W-1:0]]];
      out_data.position    <= idx[3:0];
      out_data.last        <= st.emit_last;
      out_data.error       <= 1'b0;
    end else if (cmd.emit_err) begin
      out_data.out_task_id <= '0;
      out_data.position    <= '0;
      out_data.last        <= 1'b1;
      out_data.error       <= 1'b1;
    end
  end

  `POCE_ASSERT_NXT(a_clear_empties, cmd.clear, !any_edge && !bad_flag, "run state not cleared")
  `POCE_ASSERT_NXT(a_walk_bound, cmd.walk_step, len <= count, "chain longer than count")
  `POCE_ASSERT_NXT(a_last_marked, cmd.emit_step && st.emit_last, out_data.last && !out_data.error, "final transfer not marked")
  `POCE_ASSERT_NXT(a_err_shape, cmd.emit_err, out_valid && out_data.error && out_data.last, "bad error transfer")
  `POCE_ASSERT_IMP(a_no_load_busy, in_fire, !cmd.close_step && !cmd.walk_step && !cmd.emit_step, "input taken mid-run")

endmodule

`default_nettype wire

[sv/partial_order_chain_extract.sv]
// ----------------------------------------------------------------------------
// partial_order_chain_extract
// Transitive closure and reduction of a task order, emitted as one chain.
// ----------------------------------------------------------------------------
//  channel  dir  transfer
//  in_ch    in   load subtask id, load edge, or go with task count
//  out_ch   out  one task id per chain position, or one error transfer
//
//  Load items are taken while idle; ready is high whenever no run is active.
//  A go item runs check, closure over N pivots, marking of N rows, prune, end search,
//  a walk of the L-entry chain, L emits and a clear step,
//  N = task count, L = chain length; one pivot/row per closure/marking cycle.
//  Output stalls hold the sequencer in its emit or error step; reset clears matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_order_chain_extract import poce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  poce_in_if.sink    in_ch,
  poce_out_if.source out_ch
);

  cmd_t    cmd;
  status_t st;

  poce_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  poce_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

`default_nettype wire

[dv/partial_order_chain_extract_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_order_chain_extract_tb
// Loads task ids and ordering pairs, fires go items, and checks every emitted
// chain entry against an in-bench model of closure, reduction and the walk.
// ----------------------------------------------------------------------------

module partial_order_chain_extract_tb;
  import poce_pkg::*;

  localparam int N_RANDOM     = 220;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_LEN    = 40;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  poce_in_if  in_ch ();
  poce_out_if out_ch ();

  partial_order_chain_extract dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [MAX_TASKS-1:0]    order_rows [MAX_TASKS];
  logic [TASK_ID_BITS-1:0] slot_ids   [MAX_TASKS];

  in_item_t  item_q  [$];
  out_item_t chain_q [$];
  out_item_t got, want;

  int n_in, n_go, n_results, n_err_runs, longest, fails, quiet;
  int stim_items, directed_items;
  bit in_took;

  // model of one go item: closure, reduction, end search, predecessor walk
  function automatic void predict_chain(input logic [4:0] cnt);
    logic [MAX_TASKS-1:0] live, m;
    logic [MAX_TASKS-1:0] marks [MAX_TASKS];
    logic [3:0]           walk  [MAX_TASKS];
    int n, i, j, k, len, cur, nxt;
    bit fail, found, done;
    out_item_t r;
    n = cnt;
    len = 0;
    cur = 0;
    nxt = 0;
    fail = (n == 0 || n > MAX_TASKS);
    live = (n >= MAX_TASKS) ? '1 : MAX_TASKS'((1 << n) - 1);
    if (!fail) begin
      for (i = 0; i < MAX_TASKS; i++)
        if (order_rows[i] != '0 && (i >= n || (order_rows[i] & ~live) != '0))
          fail = 1'b1;
    end
    if (!fail) begin
      for (k = 0; k < n; k++)
        for (i = 0; i < n; i++)
          if (order_rows[i][k]) order_rows[i] |= order_rows[k];
      for (i = 0; i < n; i++) begin
        m = '0;
        for (j = 0; j < n; j++)
          if (order_rows[i][j]) m |= order_rows[j];
        marks[i] = m;
      end
      for (i = 0; i < n; i++) order_rows[i] &= ~marks[i];
      found = 1'b0;
      for (i = 0; i < n; i++)
        if (!found && order_rows[i] == '0) begin
          cur = i;
          found = 1'b1;
        end
      fail = !found;
    end
    if (!fail) begin
      walk[0] = 4'(cur);
      len = 1;
      done = 1'b0;
      while (!done && !fail) begin
        found = 1'b0;
        for (i = 0; i < n; i++)
          if (!found && order_rows[i][cur]) begin
            nxt = i;
            found = 1'b1;
          end
        if (!found) begin
          done = 1'b1;
        end else if (len >= n) begin
          fail = 1'b1;
        end else begin
          cur = nxt;
          walk[len] = 4'(cur);
          len++;
        end
      end
    end
    if (fail) begin
      r.out_task_id = '0;
      r.position    = '0;
      r.last        = 1'b1;
      r.error       = 1'b1;
      chain_q.insert(chain_q.size(), r);
      n_err_runs++;
    end else begin
      for (k = 0; k < len; k++) begin
        r.out_task_id = slot_ids[walk[len-1-k]];
        r.position    = 4'(k);
        r.last        = (k == len - 1);
        r.error       = 1'b0;
        chain_q.insert(chain_q.size(), r);
      end
      if (len > longest) longest = len;
    end
    for (i = 0; i < MAX_TASKS; i++) order_rows[i] = '0;
  endfunction

  function automatic void take_item(input in_item_t it);
    case (it.opcode)
      OP_LOAD_ID:   slot_ids[it.slot] = it.task_id;
      OP_LOAD_EDGE: order_rows[it.edge_from][it.edge_to] = 1'b1;
      OP_GO: begin
        n_go++;
        predict_chain(it.task_count);
      end
      default: ;
    endcase
  endfunction

  // unused fields carry random bits
  function automatic in_item_t rand_item(input logic [1:0] op);
    logic [63:0] bits;
    in_item_t it;
    bits = {$urandom(), $urandom()};
    it = bits[$bits(in_item_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  function automatic void push_id(input int s, input int id);
    in_item_t it;
    it = rand_item(OP_LOAD_ID);
    it.slot = 4'(s);
    it.task_id = TASK_ID_BITS'(id);
    item_q.insert(item_q.size(), it);
    stim_items++;
  endfunction

  function automatic void push_order(input int from, input int to);
    in_item_t it;
    it = rand_item(OP_LOAD_EDGE);
    it.edge_from = 4'(from);
    it.edge_to = 4'(to);
    item_q.insert(item_q.size(), it);
    stim_items++;
  endfunction

  function automatic void push_go(input int cnt);
    in_item_t it;
    it = rand_item(OP_GO);
    it.task_count = 5'(cnt);
    item_q.insert(item_q.size(), it);
    stim_items++;
  endfunction

  function automatic void push_unused();
    item_q.insert(item_q.size(), rand_item(OP_UNUSED));
  endfunction

  // one method: up to three id reloads, a set of ordering pairs, sometimes unused items, then go
  function automatic void build_method();
    int n, m, kind, t, a, b, hi;
    int perm [MAX_TASKS];
    kind = $urandom_range(99);
    if ($urandom_range(99) < 85) begin
      n = ($urandom_range(99) < 80) ? $urandom_range(2, 8) : $urandom_range(9, MAX_TASKS);
    end else begin
      t = $urandom_range(2);
      n = (t == 0) ? 0 : (t == 1) ? 1 : $urandom_range(MAX_TASKS + 1, 31);
    end
    m = (n > MAX_TASKS) ? MAX_TASKS : n;
    repeat ($urandom_range(0, 3)) push_id($urandom_range(MAX_TASKS - 1), $urandom_range(16'hFFFF));
    for (a = 0; a < MAX_TASKS; a++) perm[a] = a;
    for (a = m - 1; a > 0; a--) begin
      b = $urandom_range(a);
      t = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    end
    if (kind >= 70 && kind < 85) begin
      if (m >= 1)
        repeat ($urandom_range(1, 2 * m)) push_order($urandom_range(m - 1), $urandom_range(m - 1));
    end else if (m >= 2) begin
      if ($urandom_range(1))
        for (a = 0; a < m - 1; a++) push_order(perm[a], perm[a+1]);
      repeat ($urandom_range(0, 2 * m)) begin
        a = $urandom_range(m - 2);
        b = $urandom_range(a + 1, m - 1);
        push_order(perm[a], perm[b]);
      end
    end
    if (kind >= 85 && kind < 95 && m < MAX_TASKS) begin
      hi = $urandom_range(m, MAX_TASKS - 1);
      if ($urandom_range(1)) push_order(hi, $urandom_range(MAX_TASKS - 1));
      else push_order($urandom_range(MAX_TASKS - 1), hi);
    end
    if (kind >= 95) repeat ($urandom_range(1, 3)) push_unused();
    push_go(n);
  endfunction

  function automatic int idle_pct(input bit rx);
    case ((n_in / PHASE_LEN) % 4)
      1:       return rx ? 0 : 62;
      2:       return rx ? 62 : 0;
      3:       return 26;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      take_item(in_ch.data);
      n_in++;
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (item_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        in_ch.data  <= item_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b1 : ($urandom_range(99) >= idle_pct(1'b1));
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_results++;
      if (chain_q.size() == 0) begin
        $error("result with nothing expected: id %0h pos %0d last %0b err %0b",
               got.out_task_id, got.position, got.last, got.error);
        fails++;
      end else begin
        want = chain_q.pop_front();
        if (got.out_task_id !== want.out_task_id) begin
          $error("out_task_id: expected %0h, got %0h", want.out_task_id, got.out_task_id);
          fails++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          fails++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fails++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, got.error);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet, chain_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) order_rows[i] = '0;

    // every slot gets an id so no walk reads an empty one
    for (int s = 0; s < MAX_TASKS; s++)
      push_id(s, (s == 0) ? 0 : (s == MAX_TASKS - 1) ? 16'hFFFF : $urandom_range(16'hFFFF));
    push_unused();
    push_order(0, 1);
    push_order(1, 2);
    push_order(0, 2);
    push_go(3);
    push_go(0);
    push_order(MAX_TASKS - 1, 0);
    push_go(MAX_TASKS);
    push_order(MAX_TASKS - 1, 0);
    push_go(4);
    push_go(MAX_TASKS + 1);
    push_order(0, 1);
    push_order(1, 0);
    push_go(2);
    directed_items = stim_items;
    while (stim_items < directed_items + N_RANDOM) build_method();

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (item_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (chain_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input transfers, %0d go runs (%0d error runs), %0d results checked",
             n_in, n_go, n_err_runs, n_results);
    $display("longest chain %0d tasks, %0d mismatches", longest, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
